// ===== rtl/swm_pkg.sv =====
// Shared constants, types and codes of the sliding window median filter.
package swm_pkg;

	localparam int WINDOW_MAX  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_BITS    = 6;
	localparam int IDX_BITS    = $clog2(WINDOW_MAX);
	localparam int FILL_BITS   = IDX_BITS + 1;
	localparam int AGE_BITS    = IDX_BITS;

	localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(5);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [AGE_BITS-1:0]    age_t;
	typedef logic [FILL_BITS-1:0]   fill_t;
	typedef logic [IDX_BITS-1:0]    idx_t;

	// Contents of one sorting cell.
	typedef struct packed {
		logic    valid;
		sample_t value;
		age_t    age;
	} cell_t;

	// Operation broadcast to every cell in the same cycle.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_DELETE = 2'd2,
		OP_INSERT = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		sample_t  value;
		age_t     oldest;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WORK = 3'b010,
		S_SEL  = 3'b100
	} state_t;

endpackage

// ===== rtl/swm_in_if.sv =====
// Input channel of the median filter: one sample and its start flag.
interface swm_in_if;
	import swm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink (input valid, input sample, input start_req, output ready);
endinterface

// ===== rtl/swm_out_if.sv =====
// Output channel of the median filter: the median as floor plus half flag.
interface swm_out_if;
	import swm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t median_floor;
	logic    median_half;

	modport source (output valid, output median_floor, output median_half, input ready);
	modport sink (input valid, input median_floor, input median_half, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
// One cell of the sorted sample chain, with its neighbor hand-off logic.
module swm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  swm_pkg::cell_cmd_t cmd,
	input  swm_pkg::cell_t    left_q,
	input  swm_pkg::cell_t    right_q,
	input  logic              left_gt,
	input  logic              del_in,
	output swm_pkg::cell_t    cell_q,
	output logic              gt,
	output logic              del_out
);
	import swm_pkg::*;

	cell_t cell_d;
	logic  del_here;

	// Empty cells sort as larger than any sample, so they stay at the tail.
	assign gt       = !cell_q.valid || (cmd.value < cell_q.value);
	assign del_here = cell_q.valid && (cell_q.age == cmd.oldest);
	assign del_out  = del_in | del_here;

	always_comb begin
		cell_d = cell_q;
		case (cmd.op)
			OP_CLEAR: begin
				cell_d.valid = 1'b0;
			end
			OP_DELETE: begin
				if (del_out) begin
					cell_d = right_q;
				end
			end
			OP_INSERT: begin
				if (left_gt) begin
					cell_d     = left_q;
					cell_d.age = left_q.age + age_t'(1);
				end else if (gt) begin
					cell_d.valid = 1'b1;
					cell_d.value = cmd.value;
					cell_d.age   = '0;
				end else begin
					cell_d.age = cell_q.age + age_t'(1);
				end
			end
			default: begin
				cell_d = cell_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= cell_d;
		end
	end
endmodule

// ===== rtl/sliding_window_median.sv =====
// Sliding window median filter over a sorted chain of sample cells.
//
// Samples arrive on sample_ch, one per transaction; a transaction with start_req
// high empties the window before its sample is stored. Each sample that brings
// the window to exactly window_size entries yields one transaction on median_ch:
// the median floor plus a half flag, which is set only for an even window whose
// two middle values have an odd sum. Samples that leave the window short of full
// yield no result. window_size is to be written through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. Zero acts as one and values
// above 32 act as 32. Each sample is handled in turn; the next is taken only when
// the block is idle again. The steps are acceptance, a drop of each sample from the
// front of the window until there is room, the sorted insertion, and the median
// pick, which follows only when the insertion fills the window.
// The chain carries out one broadcast operation per cycle:
// a single drop or a single insertion.
// Reset empties the window and sets window_size to 5. A result waits in the
// output register while median_ch is stalled; the next sample is still taken,
// but its own result waits until the register has been emptied.
module sliding_window_median (
	input  logic                        clk,
	input  logic                        arst_n,
	swm_in_if.sink                      sample_ch,
	swm_out_if.source                   median_ch,
	input  logic                        cfg_we,
	input  logic [swm_pkg::CFG_BITS-1:0] cfg_wdata
);
	import swm_pkg::*;

	logic [CFG_BITS-1:0] wsize_q;
	logic [CFG_BITS-1:0] weff;
	state_t              state_q;
	fill_t               fill_q;
	sample_t             smp_q;
	sample_t             floor_q;
	logic                half_q;
	logic                out_valid_q;

	cell_cmd_t           cmd;
	cell_t               cells_q [WINDOW_MAX];
	logic                gt      [WINDOW_MAX];
	logic                del     [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] valid_vec;

	logic                accept;
	logic                out_take;
	logic                load_out;
	logic                win_full;
	idx_t                lo_idx;
	idx_t                hi_idx;
	sample_t             lo_val;
	sample_t             hi_val;
	logic [SAMPLE_BITS:0] mid_sum;

	// Effective window: zero is one sample, anything above the chain length saturates.
	always_comb begin
		if (wsize_q == '0) begin
			weff = CFG_BITS'(1);
		end else if (wsize_q > CFG_BITS'(WINDOW_MAX)) begin
			weff = CFG_BITS'(WINDOW_MAX);
		end else begin
			weff = wsize_q;
		end
	end

	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign out_take        = out_valid_q && median_ch.ready;
	assign load_out        = (state_q == S_SEL) && (!out_valid_q || median_ch.ready);
	assign win_full        = (FILL_BITS'(weff) <= fill_q);

	// Middle positions of the sorted chain; they coincide for an odd window, so
	// the sum below is twice the middle value with the half flag clear.
	assign lo_idx = IDX_BITS'((weff - CFG_BITS'(1)) >> 1);
	assign hi_idx = IDX_BITS'(weff >> 1);

	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			lo_val = lo_val | (cells_q[i].value & {SAMPLE_BITS{lo_idx == IDX_BITS'(i)}});
			hi_val = hi_val | (cells_q[i].value & {SAMPLE_BITS{hi_idx == IDX_BITS'(i)}});
		end
	end

	assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};

	// Command broadcast to the chain. The oldest stored sample always carries the
	// age fill_count minus one, since ages of stored samples run without gaps.
	always_comb begin
		cmd.op     = OP_HOLD;
		cmd.value  = smp_q;
		cmd.oldest = AGE_BITS'(fill_q - fill_t'(1));
		case (state_q)
			S_IDLE: begin
				if (accept && sample_ch.start_req) begin
					cmd.op = OP_CLEAR;
				end
			end
			S_WORK: begin
				cmd.op = win_full ? OP_DELETE : OP_INSERT;
			end
			default: begin
				cmd.op = OP_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		cell_t left_c;
		cell_t right_c;
		logic  left_g;
		logic  del_i;

		if (i == 0) begin : g_head
			assign left_c = '0;
			assign left_g = 1'b0;
			assign del_i  = 1'b0;
		end else begin : g_body
			assign left_c = cells_q[i-1];
			assign left_g = gt[i-1];
			assign del_i  = del[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_tail
			assign right_c = '0;
		end else begin : g_mid
			assign right_c = cells_q[i+1];
		end

		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left_q  (left_c),
			.right_q (right_c),
			.left_gt (left_g),
			.del_in  (del_i),
			.cell_q  (cells_q[i]),
			.gt      (gt[i]),
			.del_out (del[i])
		);

		assign valid_vec[i] = cells_q[i].valid;
	end

	// Sequencer: drop from the front until there is room, insert, then pick once the window is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WORK;
						if (sample_ch.start_req) begin
							fill_q <= '0;
						end
					end
				end
				S_WORK: begin
					if (win_full) begin
						fill_q <= fill_q - fill_t'(1);
					end else begin
						fill_q <= fill_q + fill_t'(1);
						if (fill_q + fill_t'(1) == FILL_BITS'(weff)) begin
							state_q <= S_SEL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SEL: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample_ch.sample;
		end
		if (load_out) begin
			floor_q <= mid_sum[SAMPLE_BITS:1];
			half_q  <= mid_sum[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			wsize_q     <= WINDOW_RESET;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				wsize_q <= cfg_wdata;
			end
		end
	end

	assign median_ch.valid        = out_valid_q;
	assign median_ch.median_floor = floor_q;
	assign median_ch.median_half  = half_q;

`ifndef ASSERT_OFF
	// The number of occupied cells always matches the fill count.
	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_BITS'($countones(valid_vec)) == fill_q)
		else $error("occupied cell count differs from fill count");

	// Occupied cells form an unbroken run from the head of the chain.
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("gap in the occupied cells");

	// A result appears only after the median pick step.
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SEL))
		else $error("result loaded outside the pick step");

	// An odd window never yields a half.
	a_odd_half: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && weff[0]) |-> !half_q)
		else $error("half flag set for an odd window");
`endif
endmodule
